[rtl/byte_histogram_top_assert.svh]
// assertion macros shared by the byte histogram rtl
// expects signals named clk and rst in the including module
`ifndef BYTE_HISTOGRAM_TOP_ASSERT_SVH
`define BYTE_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte histogram check failed");

// next-cycle implication, disabled during reset
`define BH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte histogram check failed");

`endif

[rtl/bhist_pkg.sv]
// types and constants for the byte histogram
// no dependencies
`timescale 1ns / 1ps

package bhist_pkg;

  localparam int OP_W            = 2;
  localparam int BYTE_W          = 8;
  localparam int RESULT_W        = 32;
  localparam int BIN_COUNT_DEF   = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] byte_value;
  } req_t;

  // stage one occupancy, seen by the top level
  typedef struct packed {
    logic valid;
    logic query;
  } stage_t;

endpackage

[rtl/bhist_ifs.sv]
// valid/ready channel interfaces for the byte histogram
// depends on bhist_pkg
`timescale 1ns / 1ps

interface bhist_req_if import bhist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] byte_value;

  modport source(output valid, operation, byte_value, input ready);
  modport sink(input valid, operation, byte_value, output ready);
endinterface

interface bhist_rsp_if import bhist_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] bin_count;

  modport source(output valid, bin_count, input ready);
  modport sink(input valid, bin_count, output ready);
endinterface

[rtl/bhist_core.sv]
// bin memory with valid bits, read-modify-write stage and forwarding
// depends on bhist_pkg and byte_histogram_top_assert.svh
`timescale 1ns / 1ps
`include "byte_histogram_top_assert.svh"

module bhist_core import bhist_pkg::*; #(
  parameter int BIN_COUNT   = BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  req_t                req,
  input  logic                advance,
  output stage_t              status,
  output logic [RESULT_W-1:0] bin_count
);

  localparam int ADDR_W = $clog2(BIN_COUNT);

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [BIN_COUNT-1:0]   bin_valid;

  logic                   s1_valid;
  logic                   s1_query;
  logic                   s1_in_range;
  logic [ADDR_W-1:0]      s1_addr;
  logic                   s1_fwd;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic                   op_clear;
  logic                   op_count;
  logic                   op_query;
  logic [ADDR_W-1:0]      req_addr;
  logic                   req_in_range;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic                   wr_en;
  logic [RESULT_W-1:0]    cnt_low;

  always_comb begin
    op_clear = 1'b0;
    op_count = 1'b0;
    op_query = 1'b0;
    case (req.op)
      OP_CLEAR: op_clear = 1'b1;
      OP_COUNT: op_count = 1'b1;
      OP_QUERY: op_query = 1'b1;
      default: ;
    endcase
  end

  assign req_addr     = req.byte_value[ADDR_W-1:0];
  assign req_in_range = {1'b0, req.byte_value} < (BYTE_W + 1)'(BIN_COUNT);

  // forwarded value wins over memory; invalid entries read as zero
  assign cnt_cur  = s1_fwd ? fwd_data : (bin_valid[s1_addr] ? rdata : '0);
  assign cnt_next = cnt_cur + COUNT_WIDTH'(1);
  assign wr_en    = s1_valid && !s1_query && s1_in_range && advance;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= cnt_next;
    end
    if (fire) begin
      rdata <= mem[req_addr];
    end
  end

  // clear of the whole store wins over a write in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (fire && op_clear) begin
      bin_valid <= '0;
    end else if (wr_en) begin
      bin_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= fire && (op_count || op_query);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      s1_query    <= op_query;
      s1_in_range <= req_in_range;
      s1_addr     <= req_addr;
      s1_fwd      <= wr_en && (s1_addr == req_addr);
      fwd_data    <= cnt_next;
    end
  end

  generate
    if (COUNT_WIDTH >= RESULT_W) begin : g_trunc
      assign cnt_low = cnt_cur[RESULT_W-1:0];
    end else begin : g_ext
      assign cnt_low = {{(RESULT_W - COUNT_WIDTH){1'b0}}, cnt_cur};
    end
  endgenerate

  assign bin_count    = s1_in_range ? cnt_low : '0;
  assign status.valid = s1_valid;
  assign status.query = s1_query;

  `BH_ASSERT_NOW(a_fwd_from_write, $past(fire) && s1_fwd, $past(wr_en))
  `BH_ASSERT_NEXT(a_clear_drops_all, fire && op_clear, bin_valid == '0)
  `BH_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid && $stable(s1_addr))

endmodule

[rtl/byte_histogram_top.sv]
// byte histogram top level: request handshake, bin core, result register
// depends on bhist_pkg, bhist_ifs, bhist_core and byte_histogram_top_assert.svh
`timescale 1ns / 1ps
`include "byte_histogram_top_assert.svh"

// channel  role  payload
// -------  ----  ------------------------------------------
// req      sink  operation (2 b), byte_value (8 b)
// rsp      src   bin_count (32 b), one per query request
//
// one request per cycle while req is not stalled; a query's bin memory read is
// registered, then the increment/select stage feeds the result register.
// counts to the same bin in back-to-back cycles are forwarded, no bubble.
// reset clears all bins at once through per-bin valid bits; a clear request
// does the same when it is taken. req.ready is low during reset.
// req stalls only while a query waits behind a full, unread result register.

module byte_histogram_top import bhist_pkg::*; #(
  parameter int BIN_COUNT   = BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  bhist_req_if.sink    req,
  bhist_rsp_if.source  rsp
);

  req_t                core_req;
  stage_t              status;
  logic [RESULT_W-1:0] core_count;
  logic                fire;
  logic                hold;
  logic                out_valid;
  logic [RESULT_W-1:0] out_data;

  // a query in stage one can only move on if the result register frees up
  assign hold      = status.valid && status.query && out_valid && !rsp.ready;
  assign req.ready = !rst && !hold;
  assign fire      = req.valid && req.ready;

  assign core_req.op         = op_t'(req.operation);
  assign core_req.byte_value = req.byte_value;

  bhist_core #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (core_req),
    .advance   (!hold),
    .status    (status),
    .bin_count (core_count)
  );

  // result register, decouples the core from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= status.valid && status.query;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      out_data <= core_count;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.bin_count = out_data;

  `BH_ASSERT_NOW(a_result_from_query, $rose(out_valid), $past(status.valid && status.query))
  `BH_ASSERT_NOW(a_stall_needs_result, !req.ready, out_valid)
  `BH_ASSERT_NEXT(a_result_holds, out_valid && !rsp.ready, out_valid && $stable(out_data))

endmodule

[sim/byte_histogram_checker.sv]
// watches both byte histogram channels, keeps its own copy of the bins
// and checks each query result against it; depends on bhist_pkg, bhist_ifs
`timescale 1ns / 1ps

module byte_histogram_checker import bhist_pkg::*; #(
  parameter int BIN_COUNT   = BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  bhist_req_if  req,
  bhist_rsp_if  rsp,
  output int    fail_count,
  output int    outstanding
);

  localparam logic [63:0] COUNT_MASK =
    (COUNT_WIDTH >= 64) ? '1 : ((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [63:0]         tally [BIN_COUNT];
  logic [RESULT_W-1:0] pending_counts [$];

  // applies one accepted request to the bin copy, queues a query's count
  task automatic tally_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] sel);
    logic in_range;
    in_range = int'(sel) < BIN_COUNT;
    case (op)
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      OP_COUNT: begin
        if (in_range) tally[sel] = (tally[sel] + 64'd1) & COUNT_MASK;
      end
      OP_QUERY: begin
        pending_counts.push_back(in_range ? tally[sel][RESULT_W-1:0] : '0);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic [RESULT_W-1:0] expected;
    if (rst) begin
      foreach (tally[i]) tally[i] = '0;
      pending_counts.delete();
      fail_count = 0;
    end else begin
      // results first: a query accepted now cannot come out at this edge
      if (rsp.valid && rsp.ready) begin
        if (pending_counts.size() == 0) begin
          $error("bin_count unexpected: expected none, actual %0d", rsp.bin_count);
          fail_count++;
        end else begin
          expected = pending_counts.pop_front();
          if (rsp.bin_count !== expected) begin
            $error("bin_count mismatch: expected %0d, actual %0d", expected, rsp.bin_count);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) tally_request(req.operation, req.byte_value);
    end
    outstanding = pending_counts.size();
  end

endmodule

[sim/tb_byte_histogram_top.sv]
// top of the byte histogram testbench: clock, reset, request and result drivers
// depends on bhist_pkg, bhist_ifs, byte_histogram_top and byte_histogram_checker
`timescale 1ns / 1ps

module tb_byte_histogram_top import bhist_pkg::*;;

  localparam int BIN_COUNT    = BIN_COUNT_DEF;
  localparam int COUNT_WIDTH  = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  // worst case with both sides stalling is far below this
  localparam int CYCLE_LIMIT  = 400000;
  // operation code the block has to ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  // when set, neither side idles: back-to-back requests and results
  logic steady = 1'b0;
  int   fail_count;
  int   outstanding;

  bhist_req_if req ();
  bhist_rsp_if rsp ();

  byte_histogram_top #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  byte_histogram_checker #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // one request: optional idle gap, then hold valid until the block takes it.
  // ready is sampled at the falling edge, where it is settled for the next
  // rising edge, so the handshake test never races the block's own update
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] sel);
    int   gap;
    logic taken;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.byte_value <= sel;
    do begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // hold off new requests until every queued query result has come back
  task automatic wait_for_results();
    req.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // result side: a random stall before each result, then ready until one is taken
  initial begin : result_sink
    int   stall;
    logic taken;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = rsp.valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  // hard stop if the block hangs or a result never arrives
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int                counted;
    int                seg_len;
    int                roll;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] window;
    logic [BYTE_W-1:0] noise;
    logic [BYTE_W-1:0] sel;
    logic [OP_W-1:0]   op;

    req.valid      <= 1'b0;
    req.operation  <= OP_CLEAR;
    req.byte_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, back to back so the same-bin forwarding path is hit
    steady = 1'b1;
    // bins read zero straight after reset, lowest and highest byte
    send_request(OP_QUERY, 8'h00);
    send_request(OP_QUERY, 8'hFF);
    send_request(OP_COUNT, 8'h00);
    send_request(OP_COUNT, 8'hFF);
    send_request(OP_COUNT, 8'hFF);
    send_request(OP_QUERY, 8'h00);
    send_request(OP_QUERY, 8'hFF);
    // repeated counts to one bin in consecutive cycles
    repeat (4) send_request(OP_COUNT, 8'h80);
    send_request(OP_QUERY, 8'h80);
    // query right behind a count of the same bin
    send_request(OP_COUNT, 8'h55);
    send_request(OP_QUERY, 8'h55);
    // unused operation code must leave the bin alone
    send_request(OP_UNUSED, 8'hAA);
    send_request(OP_QUERY, 8'hAA);
    // clear wipes everything, whatever its byte field
    send_request(OP_CLEAR, 8'h00);
    send_request(OP_QUERY, 8'hFF);
    send_request(OP_QUERY, 8'h80);
    send_request(OP_COUNT, 8'hAA);
    send_request(OP_CLEAR, 8'hFF);
    send_request(OP_QUERY, 8'hAA);
    send_request(OP_COUNT, 8'h7F);
    send_request(OP_QUERY, 8'h7F);
    steady = 1'b0;
    // sender pauses here until the whole directed part is answered
    wait_for_results();

    // random part: segments over a window of 4, 16 or all 256 bins, the small ones so
    // counts build up, each with its own idling mode; ignored requests are not counted
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 150);
      steady  = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin
          window = 8'h03;
        end
        1: begin
          window = 8'h0F;
        end
        default: begin
          window = 8'hFF;
        end
      endcase
      base = BYTE_W'($urandom);
      for (int k = 0; k < seg_len && counted < RANDOM_ITEMS; k++) begin
        roll  = $urandom_range(0, 99);
        noise = BYTE_W'($urandom);
        sel   = base ^ (noise & window);
        if (roll < 55) op = OP_COUNT;
        else if (roll < 92) op = OP_QUERY;
        else if (roll < 97) op = OP_UNUSED;
        else op = OP_CLEAR;
        send_request(op, sel);
        if (op != OP_UNUSED) counted++;
      end
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end
    steady = 1'b0;

    // drain, then idle for anything still in the pipeline
    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
